// File: src/dsse_pkg.sv
// ----------------------------------------------------------------------------
// dsse_pkg
// Shared types, codes, constants and the sine table builder for the
// damped sine scale envelope.
// ----------------------------------------------------------------------------
package dsse_pkg;

    // default parameter values
    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int SCALE_FRAC_BITS_DEF  = 12;

    // width of the shared multiplier operands
    localparam int MUL_W = 32;

    // opcodes of an input beat
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_GROW   = 2'd1;
    localparam logic [1:0] OP_SHRINK = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // envelope modes, as reported in phase_state
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_GROW   = 2'd1;
    localparam logic [1:0] MODE_SHRINK = 2'd2;
    localparam logic [1:0] MODE_WAIT   = 2'd3;

    // reset values of the loaded parameters
    localparam logic [15:0] RESET_AMPLITUDE = 16'd16384;
    localparam logic [15:0] RESET_RATE      = 16'd256;
    localparam logic [15:0] RESET_SPAN      = 16'd4096;

    // delays below 0.01 s in Q4.12 start growing at once
    localparam logic [15:0] SHORT_DELAY = 16'd41;

    // sine of a quarter turn in Q1.14
    localparam logic [14:0] SIN_ONE = 15'd16384;

    // pi/2 in Q2.30 and 1/(2 pi) in Q0.32
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] strength;
        logic [15:0] angular_rate;
        logic [15:0] duration;
        logic [15:0] delay;
        logic [15:0] delta_time;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] scale;
        logic [1:0]         phase_state;
    } t_out_beat;

    // Taylor series of sin(a) up to the ninth power, angle in Q2.30,
    // result rounded half up to Q1.14. Evaluated at elaboration only.
    function automatic logic [14:0] quarter_sine(input logic [63:0] angle);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rounded;
        sum  = angle;
        term = angle;
        term = (((term * angle) >> 30) * angle) >> 30;
        term = term / 64'd6;
        sum  = sum - term;
        term = (((term * angle) >> 30) * angle) >> 30;
        term = term / 64'd20;
        sum  = sum + term;
        term = (((term * angle) >> 30) * angle) >> 30;
        term = term / 64'd42;
        sum  = sum - term;
        term = (((term * angle) >> 30) * angle) >> 30;
        term = term / 64'd72;
        sum  = sum + term;
        rounded = (sum + 64'd32768) >> 16;
        return rounded[14:0];
    endfunction

endpackage

// File: src/dsse_stream_if.sv
// ----------------------------------------------------------------------------
// dsse_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface dsse_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/dsse_mul.sv
// ----------------------------------------------------------------------------
// dsse_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module dsse_mul
    import dsse_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic [2*MUL_W-1:0] o_prod
);
    logic [2*MUL_W-1:0] r_prod;

    // register the full product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// File: src/dsse_sine_rom.sv
// ----------------------------------------------------------------------------
// dsse_sine_rom
// Quarter-wave sine table in Q1.14 with a registered read port.
// ----------------------------------------------------------------------------
module dsse_sine_rom
    import dsse_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int ADDR_W           = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [14:0]       o_data
);
    logic [14:0] w_tab [SINE_TABLE_DEPTH];
    logic [14:0] r_data;

    // build entry k = sin(pi/2 * k / depth) at elaboration
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        assign w_tab[k] = quarter_sine(ANGLE);
    end

    // read one entry per cycle
    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;
endmodule

// File: src/damped_sine_scale_envelope.sv
// ----------------------------------------------------------------------------
// damped_sine_scale_envelope
// Pulse envelope for a display scale: 1 +/- (D - t)(A sin(wt) + A), Q4.12.
// Sequencing: start, wait, idle and unused beats go from acceptance straight
//   to the emit state; an envelope tick first passes the phase, turn, index,
//   look, inner, env and done states: five passes through the one shared
//   32x32 multiplier plus the sine table read. No new beat is taken until the
//   last one is emitted, which waits while the previous result beat is stalled.
// Reset (synchronous, active low): idle, scale 1.0, default parameters;
//   the sine table is constant, so no clearing pass.
// ----------------------------------------------------------------------------
module damped_sine_scale_envelope
    import dsse_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SCALE_FRAC_BITS  = SCALE_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsse_stream_if.sink   i_in,
    dsse_stream_if.source o_out
);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SHIFT = 40 - SCALE_FRAC_BITS;
    localparam int VW    = 10 + SCALE_FRAC_BITS;
    localparam logic signed [VW-1:0] ONE    = VW'(1 << SCALE_FRAC_BITS);
    localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
    localparam logic signed [VW-1:0] SAT_LO = -(VW'(32768));
    localparam logic [15:0] ONE_16 = 16'(1 << SCALE_FRAC_BITS);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHASE = 4'd1;
    localparam logic [3:0] S_TURN  = 4'd2;
    localparam logic [3:0] S_INDEX = 4'd3;
    localparam logic [3:0] S_LOOK  = 4'd4;
    localparam logic [3:0] S_INNER = 4'd5;
    localparam logic [3:0] S_ENV   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_elapsed, n_elapsed;
    logic [16:0] r_wait_left, n_wait_left;
    logic [15:0] r_amp, n_amp;
    logic [15:0] r_rate, n_rate;
    logic [15:0] r_span, n_span;
    logic [15:0] r_scale, n_scale;
    logic [1:0]  r_quad, n_quad;
    logic        r_idx_zero, n_idx_zero;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out_beat, n_out_beat;

    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_prod;
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_addr;
    logic [IDX_W:0]     w_mirror;
    logic [14:0]        w_rom;
    logic [14:0]        w_sin_mag;
    logic [15:0]        w_sin_off;
    logic [16:0]        w_t_sum;
    logic [15:0]        w_t;
    logic [17:0]        w_wait_sub;
    logic signed [VW-1:0] w_delta, w_v;
    t_in_beat           w_in;

    assign w_in = i_in.payload;

    // saturating elapsed time
    assign w_t_sum = {1'b0, r_elapsed} + {1'b0, w_in.delta_time};
    assign w_t     = w_t_sum[16] ? 16'hFFFF : w_t_sum[15:0];

    // wait countdown, sign bit tells expiry
    assign w_wait_sub = {1'b0, r_wait_left} - {2'b00, w_in.delta_time};

    // table index from the registered index product, mirrored in odd quadrants
    assign w_idx    = w_prod[30 +: IDX_W];
    assign w_mirror = (IDX_W + 1)'(SINE_TABLE_DEPTH) - {1'b0, w_idx};
    assign w_addr   = r_quad[0] ? w_mirror[IDX_W-1:0] : w_idx;

    // sine magnitude and the sin + 1 offset term
    assign w_sin_mag = (r_idx_zero && r_quad[0]) ? SIN_ONE : w_rom;
    assign w_sin_off = r_quad[1] ? (16'(SIN_ONE) - {1'b0, w_sin_mag})
                                 : (16'(SIN_ONE) + {1'b0, w_sin_mag});

    // envelope delta and signed scale before saturation
    assign w_delta = VW'(w_prod[47:0] >> SHIFT);
    assign w_v     = (r_mode == MODE_SHRINK) ? (ONE - w_delta) : (ONE + w_delta);

    dsse_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    dsse_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (IDX_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_rom)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_beat;

    // sequencer and state update
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_wait_left = r_wait_left;
        n_amp       = r_amp;
        n_rate      = r_rate;
        n_span      = r_span;
        n_scale     = r_scale;
        n_quad      = r_quad;
        n_idx_zero  = r_idx_zero;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_beat  = r_out_beat;
        w_mul_a     = '0;
        w_mul_b     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_EMIT;
                    unique case (w_in.opcode)
                        OP_GROW: begin
                            n_amp       = w_in.strength;
                            n_rate      = w_in.angular_rate;
                            n_span      = w_in.duration;
                            n_elapsed   = '0;
                            n_scale     = ONE_16;
                            n_wait_left = {1'b0, w_in.delay};
                            n_mode      = (w_in.delay < SHORT_DELAY) ? MODE_GROW : MODE_WAIT;
                        end
                        OP_SHRINK: begin
                            n_amp     = w_in.strength;
                            n_rate    = w_in.angular_rate;
                            n_span    = w_in.duration;
                            n_elapsed = '0;
                            n_scale   = ONE_16;
                            n_mode    = MODE_SHRINK;
                        end
                        OP_TICK: begin
                            unique case (r_mode)
                                MODE_GROW, MODE_SHRINK: begin
                                    if (w_t > r_span) begin
                                        // envelope over: back to rest
                                        n_mode    = MODE_IDLE;
                                        n_scale   = ONE_16;
                                        n_elapsed = '0;
                                    end else begin
                                        n_elapsed = w_t;
                                        n_state   = S_PHASE;
                                    end
                                end
                                MODE_WAIT: begin
                                    n_scale = ONE_16;
                                    if (w_wait_sub[17]) begin
                                        n_mode      = MODE_GROW;
                                        n_wait_left = '0;
                                    end else begin
                                        n_wait_left = w_wait_sub[16:0];
                                    end
                                end
                                default: begin
                                    n_scale = ONE_16;
                                end
                            endcase
                        end
                        default: begin
                            // unused opcode: report current state
                        end
                    endcase
                end
            end
            S_PHASE: begin
                // theta = t * w
                w_mul_a = {16'h0, r_elapsed};
                w_mul_b = {16'h0, r_rate};
                n_state = S_TURN;
            end
            S_TURN: begin
                // turn fraction = theta / (2 pi)
                w_mul_a = w_prod[31:0];
                w_mul_b = INV_TWO_PI_Q32;
                n_state = S_INDEX;
            end
            S_INDEX: begin
                // quadrant and position within it
                n_quad  = w_prod[51:50];
                w_mul_a = {2'b00, w_prod[49:20]};
                w_mul_b = MUL_W'(SINE_TABLE_DEPTH);
                n_state = S_LOOK;
            end
            S_LOOK: begin
                // index product is always below the depth
                n_idx_zero = (w_idx == '0);
                n_state    = S_INNER;
            end
            S_INNER: begin
                // A * (s + 1)
                w_mul_a = {16'h0, w_sin_off};
                w_mul_b = {16'h0, r_amp};
                n_state = S_ENV;
            end
            S_ENV: begin
                // (D - t) * A * (s + 1)
                w_mul_a = w_prod[31:0];
                w_mul_b = {16'h0, r_span - r_elapsed};
                n_state = S_DONE;
            end
            S_DONE: begin
                // saturate to the signed output range
                priority if (w_v > SAT_HI) begin
                    n_scale = 16'h7FFF;
                end else if (w_v < SAT_LO) begin
                    n_scale = 16'h8000;
                end else begin
                    n_scale = w_v[15:0];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid            = 1'b1;
                    n_out_beat.scale       = r_scale;
                    n_out_beat.phase_state = r_mode;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_elapsed   <= '0;
            r_wait_left <= '0;
            r_amp       <= RESET_AMPLITUDE;
            r_rate      <= RESET_RATE;
            r_span      <= RESET_SPAN;
            r_scale     <= ONE_16;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_wait_left <= n_wait_left;
            r_amp       <= n_amp;
            r_rate      <= n_rate;
            r_span      <= n_span;
            r_scale     <= n_scale;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_quad     <= n_quad;
        r_idx_zero <= n_idx_zero;
        r_out_beat <= n_out_beat;
    end
endmodule

// File: src/dsse_checker.sv
// ----------------------------------------------------------------------------
// dsse_checker
// Port-level checks for the damped sine scale envelope, bound to the top.
// ----------------------------------------------------------------------------
module dsse_checker
    import dsse_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_scale,
    input logic [1:0]  i_out_phase
);
    localparam logic [15:0] ONE_16 = 16'(1 << SCALE_FRAC_BITS);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown right after reset");

    // one item at a time: busy after every accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while previous item in work");

    // idle and waiting always report scale 1.0
    a_rest_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_phase == MODE_IDLE || i_out_phase == MODE_WAIT)
        |-> i_out_scale == ONE_16)
        else $error("scale not 1.0 while idle or waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_scale) && $stable(i_out_phase))
        else $error("stalled result beat changed");
endmodule

bind damped_sine_scale_envelope dsse_checker #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
) u_dsse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_scale (o_out.payload.scale),
    .i_out_phase (o_out.payload.phase_state)
);
